### hdl/ers_pkg.sv
// Shared constants and pipeline record types for the ellipse row span core.
// No dependencies.
package ers_pkg;

    localparam int SCREEN_WIDTH  = 256;
    localparam int SCREEN_HEIGHT = 256;

    localparam int COORD_W = 11;
    localparam int COLOR_W = 16;
    localparam int PIX_W   = 8;
    localparam int SQ_W    = 20;
    localparam int ROOT_W  = 10;
    localparam int DIV_STEPS  = SQ_W;
    localparam int SQRT_STEPS = ROOT_W;

    typedef struct packed {
        logic                      ok;
        logic signed [COORD_W-1:0] cx;
        logic [PIX_W-1:0]          row;
        logic [COLOR_W-1:0]        color;
    } t_side;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] lo;
        logic [SQ_W-1:0] den;
    } t_div;

    typedef struct packed {
        logic [SQ_W-1:0]   q;
        logic [ROOT_W-1:0] root;
    } t_sqrt;

endpackage

### hdl/ellipse_row_span_core.sv
// Ellipse scanline span: pipelined squares, product, bit-per-stage divider and
// bit-per-stage square root, then clipping. Depends on ers_pkg.
//
// Path: stage A, stage B, stage C, the divider stages, the square-root stages, then the output register.
// Throughput: one item per cycle; the whole pipeline holds while the output
// register is full and stalled, so a stall drops or repeats nothing.
// Reset: synchronous, active low; clears all stage valid bits.
module ellipse_row_span_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [ers_pkg::COORD_W-1:0] i_center_x,
    input  logic signed [ers_pkg::COORD_W-1:0] i_center_y,
    input  logic signed [ers_pkg::COORD_W-1:0] i_radius_x,
    input  logic signed [ers_pkg::COORD_W-1:0] i_radius_y,
    input  logic signed [ers_pkg::COORD_W-1:0] i_row_offset,
    input  logic [ers_pkg::COLOR_W-1:0]  i_fill_color,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_drawn,
    output logic [ers_pkg::PIX_W-1:0]    o_row_y,
    output logic [ers_pkg::PIX_W-1:0]    o_x_start,
    output logic [ers_pkg::PIX_W-1:0]    o_x_end,
    output logic [ers_pkg::COLOR_W-1:0]  o_span_color
);
    import ers_pkg::*;

    // Whole pipeline advances unless a finished result waits on a stall.
    logic w_adv;
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    // Stage A: range checks and the three squares.
    logic signed [COORD_W:0]   w_y;
    logic signed [2*COORD_W-1:0] w_rx2, w_ry2, w_dy2;
    logic                      w_ok;
    t_side                     w_side_a;
    logic                      r_va;
    t_side                     r_side_a;
    logic [SQ_W-1:0]           r_rx2, r_ry2, r_dy2;

    always_comb begin
        w_y   = {i_center_y[COORD_W-1], i_center_y} + {i_row_offset[COORD_W-1], i_row_offset};
        w_rx2 = i_radius_x * i_radius_x;
        w_ry2 = i_radius_y * i_radius_y;
        w_dy2 = i_row_offset * i_row_offset;
        w_ok  = (i_radius_x > 0) && (i_radius_y > 0)
             && (i_row_offset >= -i_radius_y) && (i_row_offset <= i_radius_y)
             && (w_y >= 0) && (w_y < (COORD_W+1)'(SCREEN_HEIGHT));
        w_side_a.ok    = w_ok;
        w_side_a.cx    = i_center_x;
        w_side_a.row   = w_y[PIX_W-1:0];
        w_side_a.color = i_fill_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (w_adv) begin
            r_va <= i_valid;
        end
        if (w_adv) begin
            r_side_a <= w_side_a;
            r_rx2    <= w_rx2[SQ_W-1:0];
            r_ry2    <= w_ry2[SQ_W-1:0];
            r_dy2    <= w_dy2[SQ_W-1:0];
        end
    end

    // Stage B: numerator factor and divisor; items failing the range checks get a safe 0 / 1.
    logic            r_vb;
    t_side           r_side_b;
    logic [SQ_W-1:0] r_rx2_b, r_k, r_den_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (w_adv) begin
            r_vb <= r_va;
        end
        if (w_adv) begin
            r_side_b <= r_side_a;
            r_rx2_b  <= r_rx2;
            r_k      <= r_side_a.ok ? (r_ry2 - r_dy2) : '0;
            r_den_b  <= r_side_a.ok ? r_ry2 : SQ_W'(1);
        end
    end

    // Stage C: 20x20 product; quotient fits 20 bits so the upper half
    // seeds the remainder.
    logic [2*SQ_W-1:0] w_num;
    logic              r_vd [0:DIV_STEPS];
    t_side             r_side_d [0:DIV_STEPS];
    t_div              r_div [0:DIV_STEPS];

    assign w_num = r_rx2_b * r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd[0] <= 1'b0;
        end else if (w_adv) begin
            r_vd[0] <= r_vb;
        end
        if (w_adv) begin
            r_side_d[0]  <= r_side_b;
            r_div[0].rem <= w_num[2*SQ_W-1:SQ_W];
            r_div[0].lo  <= w_num[SQ_W-1:0];
            r_div[0].den <= r_den_b;
        end
    end

    // Divider: one quotient bit per stage, shifted into the low word.
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        logic [SQ_W:0] w_t;
        logic          w_ge;
        t_div          n_div;
        always_comb begin
            w_t  = {r_div[g].rem, r_div[g].lo[SQ_W-1]};
            w_ge = (w_t >= {1'b0, r_div[g].den});
            n_div.den = r_div[g].den;
            n_div.rem = w_ge ? SQ_W'(w_t - {1'b0, r_div[g].den}) : w_t[SQ_W-1:0];
            n_div.lo  = {r_div[g].lo[SQ_W-2:0], w_ge};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[g+1] <= 1'b0;
            end else if (w_adv) begin
                r_vd[g+1] <= r_vd[g];
            end
            if (w_adv) begin
                r_side_d[g+1] <= r_side_d[g];
                r_div[g+1]    <= n_div;
            end
        end
    end

    // Square root: one root bit per stage, trial square compared to quotient.
    logic  r_vs [0:SQRT_STEPS];
    t_side r_side_s [0:SQRT_STEPS];
    t_sqrt r_sq [0:SQRT_STEPS];

    always_comb begin
        r_vs[0]       = r_vd[DIV_STEPS];
        r_side_s[0]   = r_side_d[DIV_STEPS];
        r_sq[0].q     = r_div[DIV_STEPS].lo;
        r_sq[0].root  = '0;
    end

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        logic [ROOT_W-1:0] w_try;
        logic [SQ_W-1:0]   w_sq;
        t_sqrt             n_sq;
        always_comb begin
            w_try     = r_sq[g].root | (ROOT_W'(1) << (SQRT_STEPS-1-g));
            w_sq      = w_try * w_try;
            n_sq.q    = r_sq[g].q;
            n_sq.root = (w_sq <= r_sq[g].q) ? w_try : r_sq[g].root;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vs[g+1] <= 1'b0;
            end else if (w_adv) begin
                r_vs[g+1] <= r_vs[g];
            end
            if (w_adv) begin
                r_side_s[g+1] <= r_side_s[g];
                r_sq[g+1]     <= n_sq;
            end
        end
    end

    // Final stage: place the span around the centre and clip to the screen.
    t_side                     w_sf;
    logic signed [COORD_W+1:0] w_x0, w_x1, w_x0c, w_x1c;
    logic                      w_draw;

    always_comb begin
        w_sf   = r_side_s[SQRT_STEPS];
        w_x0   = (COORD_W+2)'(w_sf.cx) - $signed({3'b000, r_sq[SQRT_STEPS].root});
        w_x1   = (COORD_W+2)'(w_sf.cx) + $signed({3'b000, r_sq[SQRT_STEPS].root});
        w_x0c  = (w_x0 < 0) ? '0 : w_x0;
        w_x1c  = (w_x1 > (COORD_W+2)'(SCREEN_WIDTH-1)) ? (COORD_W+2)'(SCREEN_WIDTH-1) : w_x1;
        w_draw = w_sf.ok && (w_x1c >= w_x0c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_adv) begin
            o_valid <= r_vs[SQRT_STEPS];
        end
        if (w_adv) begin
            o_drawn      <= w_draw;
            o_row_y      <= w_draw ? w_sf.row : '0;
            o_x_start    <= w_draw ? w_x0c[PIX_W-1:0] : '0;
            o_x_end      <= w_draw ? w_x1c[PIX_W-1:0] : '0;
            o_span_color <= w_draw ? w_sf.color : '0;
        end
    end

endmodule

### hdl/ers_checker.sv
// Port-level checks for ellipse_row_span_core, attached by bind.
// Depends on ers_pkg.
module ers_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic                        o_drawn,
    input logic [ers_pkg::PIX_W-1:0]   o_row_y,
    input logic [ers_pkg::PIX_W-1:0]   o_x_start,
    input logic [ers_pkg::PIX_W-1:0]   o_x_end,
    input logic [ers_pkg::COLOR_W-1:0] o_span_color
);
    import ers_pkg::*;

    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_drawn |-> o_x_start <= o_x_end)
        else $error("span start beyond end");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_drawn |-> o_row_y == 0 && o_x_start == 0 && o_x_end == 0
                                && o_span_color == 0)
        else $error("empty span carries data");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output backpressure");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_x_start) && $stable(o_x_end))
        else $error("stalled result changed");

endmodule

bind ellipse_row_span_core ers_checker u_ers_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_drawn      (o_drawn),
    .o_row_y      (o_row_y),
    .o_x_start    (o_x_start),
    .o_x_end      (o_x_end),
    .o_span_color (o_span_color)
);

### sim/tb_ellipse_row_span_core.sv
// Self-checking testbench for ellipse_row_span_core: drives ellipse rows and
// compares every span against an in-bench span calculator. Depends on ers_pkg.
`timescale 1ns / 1ps

module tb_ellipse_row_span_core;
    import ers_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] rx;
        logic signed [COORD_W-1:0] ry;
        logic signed [COORD_W-1:0] dy;
        logic [COLOR_W-1:0]        color;
    } t_row_req;

    typedef struct packed {
        logic             drawn;
        logic [PIX_W-1:0] row;
        logic [PIX_W-1:0] xs;
        logic [PIX_W-1:0] xe;
        logic [COLOR_W-1:0] color;
    } t_span;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [COORD_W-1:0] i_center_x = '0;
    logic signed [COORD_W-1:0] i_center_y = '0;
    logic signed [COORD_W-1:0] i_radius_x = '0;
    logic signed [COORD_W-1:0] i_radius_y = '0;
    logic signed [COORD_W-1:0] i_row_offset = '0;
    logic [COLOR_W-1:0] i_fill_color = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_drawn;
    logic [PIX_W-1:0] o_row_y, o_x_start, o_x_end;
    logic [COLOR_W-1:0] o_span_color;

    t_row_req pending_rows[$];
    t_span    expected_spans[$];
    int  mismatch_count = 0;
    int  idle_cycles = 0;
    bit  stimulus_done = 1'b0;
    bit  calm_phase = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;

    ellipse_row_span_core uut (.*);

    always #10 i_clk = ~i_clk;

    // Floor square root, one bit at a time.
    function automatic longint unsigned floor_root(longint unsigned q);
        longint unsigned r, t;
        r = 0;
        for (int b = 20; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= q) r = t;
        end
        return r;
    endfunction

    function automatic t_span span_of_row(t_row_req req);
        longint cx, cy, rx, ry, dy, y, hw, x0, x1;
        longint unsigned num, den;
        t_span s;
        s = '0;
        cx = longint'(req.cx);
        cy = longint'(req.cy);
        rx = longint'(req.rx);
        ry = longint'(req.ry);
        dy = longint'(req.dy);
        if (rx <= 0 || ry <= 0) return s;
        if (dy < -ry || dy > ry) return s;
        y = cy + dy;
        if (y < 0 || y >= SCREEN_HEIGHT) return s;
        den = ry * ry;
        num = (rx * rx) * (ry * ry - dy * dy);
        hw = floor_root(num / den);
        x0 = (cx - hw < 0) ? 0 : cx - hw;
        x1 = (cx + hw > SCREEN_WIDTH - 1) ? SCREEN_WIDTH - 1 : cx + hw;
        if (x1 < x0) return s;
        s.drawn = 1'b1;
        s.row = y[PIX_W-1:0];
        s.xs = x0[PIX_W-1:0];
        s.xe = x1[PIX_W-1:0];
        s.color = req.color;
        return s;
    endfunction

    function automatic t_row_req make_row(int cx, int cy, int rx, int ry, int dy, int color);
        t_row_req r;
        r.cx    = COORD_W'(cx);
        r.cy    = COORD_W'(cy);
        r.rx    = COORD_W'(rx);
        r.ry    = COORD_W'(ry);
        r.dy    = COORD_W'(dy);
        r.color = COLOR_W'(color);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // Queue a whole ellipse, every row from -ry to ry, with a single random colour.
    task automatic add_ellipse(int cx, int cy, int rx, int ry);
        int color;
        color = $urandom_range(0, 65535);
        for (int dy = -ry; dy <= ry; dy++)
            pending_rows.push_back(make_row(cx, cy, rx, ry, dy, color));
    endtask

    initial begin
        int kind, ry;
        // Directed: field extremes, degenerate radii, out-of-range offsets,
        // off-screen rows and spans clipped away entirely.
        pending_rows.push_back(make_row(100, 100, 20, 10, 0, 16'hFFFF));
        pending_rows.push_back(make_row(100, 100, 20, 10, 10, 16'h0000));
        pending_rows.push_back(make_row(100, 100, 20, 10, -10, 16'h1234));
        pending_rows.push_back(make_row(100, 100, 0, 10, 0, 16'hAAAA));
        pending_rows.push_back(make_row(100, 100, 20, 0, 0, 16'h5555));
        pending_rows.push_back(make_row(100, 100, -1024, -1024, 0, 16'hFFFF));
        pending_rows.push_back(make_row(100, 100, 20, 10, 11, 16'h0F0F));
        pending_rows.push_back(make_row(100, 100, 20, 10, -1024, 16'hF0F0));
        pending_rows.push_back(make_row(100, 100, 20, 1023, 1023, 16'h0001));
        pending_rows.push_back(make_row(0, 0, 1023, 1023, 0, 16'h8000));
        pending_rows.push_back(make_row(-1024, 5, 1023, 1023, 0, 16'h7FFF));
        pending_rows.push_back(make_row(1023, 5, 1023, 1023, 0, 16'h00FF));
        pending_rows.push_back(make_row(-1024, 5, 10, 10, 0, 16'hFF00));
        pending_rows.push_back(make_row(1023, 5, 10, 10, 0, 16'h3C3C));
        pending_rows.push_back(make_row(128, 255, 10, 10, 0, 16'hC3C3));
        pending_rows.push_back(make_row(128, 255, 10, 10, 1, 16'h1111));
        pending_rows.push_back(make_row(128, -1, 10, 10, 0, 16'h2222));
        pending_rows.push_back(make_row(128, 1023, 10, 10, -10, 16'h3333));
        pending_rows.push_back(make_row(-1024, -1024, 1023, 1023, 1023, 16'h4444));
        pending_rows.push_back(make_row(-1, 50, 1, 1, 0, 16'h6666));
        pending_rows.push_back(make_row(256, 50, 1, 1, 0, 16'h7777));
        pending_rows.push_back(make_row(255, 50, 1, 1, 0, 16'h8888));
        pending_rows.push_back(make_row(0, 0, 1, 1, 0, 16'h9999));
        // Random: mostly whole ellipses, some noise rows over the full ranges.
        while (pending_rows.size() < 420) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                ry = $urandom_range(1, 12);
                add_ellipse($urandom_range(0, 300) - 20, $urandom_range(0, 280) - 10,
                            $urandom_range(1, 200), ry);
            end else if (kind < 8) begin
                ry = $urandom_range(1, 1023);
                pending_rows.push_back(make_row($urandom_range(0, 2047) - 1024,
                    $urandom_range(0, 2047) - 1024, $urandom_range(1, 1023), ry,
                    $urandom_range(0, 2 * ry) - ry, $urandom_range(0, 65535)));
            end else begin
                pending_rows.push_back(make_row($urandom_range(0, 2047) - 1024,
                    $urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024,
                    $urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024,
                    $urandom_range(0, 65535)));
            end
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: hold the payload until the transfer completes.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_spans.push_back(span_of_row(pending_rows.pop_front()));
            end
            if (!i_valid || !o_stall) begin
                if (pending_rows.size() < 30 && !calm_phase) calm_phase = 1'b1;
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 7);
                    i_valid <= 1'b0;
                end else if (pending_rows.size() > 0) begin
                    i_valid      <= 1'b1;
                    i_center_x   <= pending_rows[0].cx;
                    i_center_y   <= pending_rows[0].cy;
                    i_radius_x   <= pending_rows[0].rx;
                    i_radius_y   <= pending_rows[0].ry;
                    i_row_offset <= pending_rows[0].dy;
                    i_fill_color <= pending_rows[0].color;
                end else begin
                    i_valid <= 1'b0;
                    stimulus_done <= 1'b1;
                end
            end
        end
    end

    // Monitor: check each span transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_span want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_spans.size() == 0) begin
                    report_mismatch("unexpected span", 1, 0);
                end else begin
                    want = expected_spans.pop_front();
                    if (o_drawn !== want.drawn)
                        report_mismatch("drawn", int'(o_drawn), int'(want.drawn));
                    if (o_row_y !== want.row)
                        report_mismatch("row_y", int'(o_row_y), int'(want.row));
                    if (o_x_start !== want.xs)
                        report_mismatch("x_start", int'(o_x_start), int'(want.xs));
                    if (o_x_end !== want.xe)
                        report_mismatch("x_end", int'(o_x_end), int'(want.xe));
                    if (o_span_color !== want.color)
                        report_mismatch("span_color", int'(o_span_color), int'(want.color));
                end
            end
            // Random stall bursts; none begins once the calm phase starts.
            if (recv_gap > 0) begin
                recv_gap--;
                i_stall <= 1'b1;
            end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(0, 7);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: count cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        wait (stimulus_done && expected_spans.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_spans.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
